[design/wpl_pkg.sv]
`default_nettype none

package wpl_pkg;

	// table geometry
	localparam int PAIR_SLOTS = 16;
	localparam int WIDE_SLOTS = 8;
	localparam int KEY_BITS   = 16;

	localparam int PIDX_W   = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
	localparam int WIDX_W   = (WIDE_SLOTS > 1) ? $clog2(WIDE_SLOTS) : 1;
	localparam int SCAN_LEN = (PAIR_SLOTS > WIDE_SLOTS) ? PAIR_SLOTS : WIDE_SLOTS;
	localparam int CNT_W    = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
	localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SCAN_LEN - 1);

	// request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// stream widths
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [2:0] {
		STAT_GRANTED  = 3'd0,
		STAT_CONFLICT = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_RELEASED = 3'd3,
		STAT_UNHELD   = 3'd4
	} status_t;

	// which kind of lock a request names
	typedef enum logic [1:0] {
		KIND_PAIR   = 2'd0,
		KIND_SRC    = 2'd1,
		KIND_TAG    = 2'd2,
		KIND_GLOBAL = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic                release_op;
		logic [KEY_BITS-1:0] src_key;
		logic [KEY_BITS-1:0] tag_key;
	} req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

[design/wpl_front.sv]
`default_nettype none

module wpl_front import wpl_pkg::*; (
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // source_key, tag_key
	input  wire logic [IN_USER_W-1:0] s_axis_tuser,  // operation, source_is_wild, tag_is_wild
	input  wire q_stat_t              q_stat,
	output logic                      push,
	output req_t                      push_req
);

	logic src_wild;
	logic tag_wild;

	assign src_wild = s_axis_tuser[1];
	assign tag_wild = s_axis_tuser[2];

	assign s_axis_tready = !q_stat.full;
	assign push          = s_axis_tvalid && !q_stat.full;

	always_comb begin
		push_req.release_op = s_axis_tuser[0];
		push_req.src_key    = KEY_BITS'(s_axis_tdata[15:0]);
		push_req.tag_key    = KEY_BITS'(s_axis_tdata[31:16]);
		// wild tag with a real source is a source-wide lock, and the mirror
		if (src_wild && tag_wild) begin
			push_req.kind = KIND_GLOBAL;
		end else if (tag_wild) begin
			push_req.kind = KIND_SRC;
		end else if (src_wild) begin
			push_req.kind = KIND_TAG;
		end else begin
			push_req.kind = KIND_PAIR;
		end
	end

endmodule

`default_nettype wire

[design/wpl_queue.sv]
`default_nettype none

module wpl_queue import wpl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_req,
	input  wire logic pop,
	output req_t      head,
	output q_stat_t   q_stat
);

	req_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = p + 1'b1;
		end
	endfunction

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

`default_nettype wire

[design/wpl_back.sv]
`default_nettype none

module wpl_back import wpl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire req_t                  head,
	input  wire q_stat_t               q_stat,
	output logic                       pop,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata   // status
);

	typedef enum logic [2:0] {
		BK_IDLE   = 3'b001,
		BK_SCAN   = 3'b010,
		BK_DECIDE = 3'b100
	} bk_state_t;

	bk_state_t state_q;

	// lock state
	logic [PAIR_SLOTS-1:0] pair_used_q;
	logic [KEY_BITS-1:0]   pair_src_q [PAIR_SLOTS];
	logic [KEY_BITS-1:0]   pair_tag_q [PAIR_SLOTS];
	logic [WIDE_SLOTS-1:0] src_used_q;
	logic [KEY_BITS-1:0]   src_key_q [WIDE_SLOTS];
	logic [WIDE_SLOTS-1:0] tag_used_q;
	logic [KEY_BITS-1:0]   tag_key_q [WIDE_SLOTS];
	logic                  global_q;

	// request under work and scan results
	req_t             req_q;
	logic [CNT_W-1:0] cnt_q;
	logic              pair_hit_q;
	logic [PIDX_W-1:0] pair_hit_idx_q;
	logic              pair_free_q;
	logic [PIDX_W-1:0] pair_free_idx_q;
	logic              pair_has_src_q;
	logic              pair_has_tag_q;
	logic              src_hit_q;
	logic [WIDX_W-1:0] src_hit_idx_q;
	logic              src_free_q;
	logic [WIDX_W-1:0] src_free_idx_q;
	logic              tag_hit_q;
	logic [WIDX_W-1:0] tag_hit_idx_q;
	logic              tag_free_q;
	logic [WIDX_W-1:0] tag_free_idx_q;

	logic    out_valid_q;
	status_t status_q;

	// one slot per scan cycle
	logic [PIDX_W-1:0] pidx;
	logic [WIDX_W-1:0] widx;
	logic p_in, w_in;
	logic p_used, p_src_eq, p_tag_eq;
	logic s_used, s_eq, t_used, t_eq;

	assign pidx     = cnt_q[PIDX_W-1:0];
	assign widx     = cnt_q[WIDX_W-1:0];
	assign p_in     = 32'(cnt_q) < PAIR_SLOTS;
	assign w_in     = 32'(cnt_q) < WIDE_SLOTS;
	assign p_used   = p_in && pair_used_q[pidx];
	assign p_src_eq = (pair_src_q[pidx] == req_q.src_key);
	assign p_tag_eq = (pair_tag_q[pidx] == req_q.tag_key);
	assign s_used   = w_in && src_used_q[widx];
	assign s_eq     = (src_key_q[widx] == req_q.src_key);
	assign t_used   = w_in && tag_used_q[widx];
	assign t_eq     = (tag_key_q[widx] == req_q.tag_key);

	logic do_decide;
	assign pop       = (state_q == BK_IDLE) && !q_stat.empty;
	assign do_decide = (state_q == BK_DECIDE) && (!out_valid_q || m_axis_tready);

	// decision
	status_t status_d;
	logic pair_set, pair_clr, src_set, src_clr, tag_set, tag_clr, glob_set, glob_clr;

	always_comb begin
		status_d = STAT_CONFLICT;
		pair_set = 1'b0;
		pair_clr = 1'b0;
		src_set  = 1'b0;
		src_clr  = 1'b0;
		tag_set  = 1'b0;
		tag_clr  = 1'b0;
		glob_set = 1'b0;
		glob_clr = 1'b0;
		case (req_q.kind)
			KIND_GLOBAL: begin
				if (req_q.release_op) begin
					status_d = global_q ? STAT_RELEASED : STAT_UNHELD;
					glob_clr = 1'b1;
				end else if (global_q || (|pair_used_q) || (|src_used_q) || (|tag_used_q)) begin
					status_d = STAT_CONFLICT;
				end else begin
					status_d = STAT_GRANTED;
					glob_set = 1'b1;
				end
			end
			KIND_SRC: begin
				if (req_q.release_op) begin
					status_d = src_hit_q ? STAT_RELEASED : STAT_UNHELD;
					src_clr  = src_hit_q;
				end else if (global_q || (|tag_used_q) || pair_has_src_q || src_hit_q) begin
					status_d = STAT_CONFLICT;
				end else if (!src_free_q) begin
					status_d = STAT_FULL;
				end else begin
					status_d = STAT_GRANTED;
					src_set  = 1'b1;
				end
			end
			KIND_TAG: begin
				if (req_q.release_op) begin
					status_d = tag_hit_q ? STAT_RELEASED : STAT_UNHELD;
					tag_clr  = tag_hit_q;
				end else if (global_q || (|src_used_q) || pair_has_tag_q || tag_hit_q) begin
					status_d = STAT_CONFLICT;
				end else if (!tag_free_q) begin
					status_d = STAT_FULL;
				end else begin
					status_d = STAT_GRANTED;
					tag_set  = 1'b1;
				end
			end
			KIND_PAIR: begin
				if (req_q.release_op) begin
					status_d = pair_hit_q ? STAT_RELEASED : STAT_UNHELD;
					pair_clr = pair_hit_q;
				end else if (global_q || src_hit_q || tag_hit_q || pair_hit_q) begin
					status_d = STAT_CONFLICT;
				end else if (!pair_free_q) begin
					status_d = STAT_FULL;
				end else begin
					status_d = STAT_GRANTED;
					pair_set = 1'b1;
				end
			end
			default: begin
				status_d = STAT_CONFLICT;
			end
		endcase
	end

	// sequencer, scan accumulators, used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_IDLE;
			cnt_q          <= '0;
			pair_hit_q     <= 1'b0;
			pair_free_q    <= 1'b0;
			pair_has_src_q <= 1'b0;
			pair_has_tag_q <= 1'b0;
			src_hit_q      <= 1'b0;
			src_free_q     <= 1'b0;
			tag_hit_q      <= 1'b0;
			tag_free_q     <= 1'b0;
			pair_used_q    <= '0;
			src_used_q     <= '0;
			tag_used_q     <= '0;
			global_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						cnt_q          <= '0;
						pair_hit_q     <= 1'b0;
						pair_free_q    <= 1'b0;
						pair_has_src_q <= 1'b0;
						pair_has_tag_q <= 1'b0;
						src_hit_q      <= 1'b0;
						src_free_q     <= 1'b0;
						tag_hit_q      <= 1'b0;
						tag_free_q     <= 1'b0;
						state_q        <= BK_SCAN;
					end
				end
				BK_SCAN: begin
					if (p_used && p_src_eq && p_tag_eq) begin
						pair_hit_q <= 1'b1;
					end
					if (p_in && !p_used) begin
						pair_free_q <= 1'b1;
					end
					if (p_used && p_src_eq) begin
						pair_has_src_q <= 1'b1;
					end
					if (p_used && p_tag_eq) begin
						pair_has_tag_q <= 1'b1;
					end
					if (s_used && s_eq) begin
						src_hit_q <= 1'b1;
					end
					if (w_in && !s_used) begin
						src_free_q <= 1'b1;
					end
					if (t_used && t_eq) begin
						tag_hit_q <= 1'b1;
					end
					if (w_in && !t_used) begin
						tag_free_q <= 1'b1;
					end
					if (cnt_q == SCAN_LAST) begin
						state_q <= BK_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				BK_DECIDE: begin
					if (do_decide) begin
						out_valid_q <= 1'b1;
						if (pair_set) begin
							pair_used_q[pair_free_idx_q] <= 1'b1;
						end
						if (pair_clr) begin
							pair_used_q[pair_hit_idx_q] <= 1'b0;
						end
						if (src_set) begin
							src_used_q[src_free_idx_q] <= 1'b1;
						end
						if (src_clr) begin
							src_used_q[src_hit_idx_q] <= 1'b0;
						end
						if (tag_set) begin
							tag_used_q[tag_free_idx_q] <= 1'b1;
						end
						if (tag_clr) begin
							tag_used_q[tag_hit_idx_q] <= 1'b0;
						end
						if (glob_set) begin
							global_q <= 1'b1;
						end
						if (glob_clr) begin
							global_q <= 1'b0;
						end
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// payload: request, first-match indices, keys, result
	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= head;
		end
		if (state_q == BK_SCAN) begin
			if (!pair_hit_q && p_used && p_src_eq && p_tag_eq) begin
				pair_hit_idx_q <= pidx;
			end
			if (!pair_free_q && p_in && !p_used) begin
				pair_free_idx_q <= pidx;
			end
			if (!src_hit_q && s_used && s_eq) begin
				src_hit_idx_q <= widx;
			end
			if (!src_free_q && w_in && !s_used) begin
				src_free_idx_q <= widx;
			end
			if (!tag_hit_q && t_used && t_eq) begin
				tag_hit_idx_q <= widx;
			end
			if (!tag_free_q && w_in && !t_used) begin
				tag_free_idx_q <= widx;
			end
		end
		if (do_decide) begin
			status_q <= status_d;
			if (pair_set) begin
				pair_src_q[pair_free_idx_q] <= req_q.src_key;
				pair_tag_q[pair_free_idx_q] <= req_q.tag_key;
			end
			if (src_set) begin
				src_key_q[src_free_idx_q] <= req_q.src_key;
			end
			if (tag_set) begin
				tag_key_q[tag_free_idx_q] <= req_q.tag_key;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(status_q);

endmodule

`default_nettype wire

[design/wildcard_pair_lock_table.sv]
`default_nettype none

// channel   | direction | transaction carries
// ----------+-----------+------------------------------------------------------------
// s_axis    | in        | tuser: operation, source_is_wild, tag_is_wild (bit 0 up)
//           |           | tdata: source_key [15:0], tag_key [31:16]
// m_axis    | out       | tdata: status [2:0], upper bits zero
//
// each request passes through the back end in order: a pop from the queue, a walk
// over max(PAIR_SLOTS, WIDE_SLOTS) slots, and a decide step that updates the table and
// waits while a status is still held on m_axis; the slot walk sets the sustained rate.
// reset clears every used bit, the global lock, the request queue and the sequencer;
// stored keys are only looked at behind a set used bit and are not cleared.
// a two-entry queue lets the input keep taking requests while the back end works,
// and the result register lets the next walk start while a status waits on m_axis.
module wildcard_pair_lock_table import wpl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // source_key, tag_key
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // operation, source_is_wild, tag_is_wild
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata    // status
);

	// front to queue
	logic push;
	req_t push_req;

	// queue to back
	req_t    head;
	q_stat_t q_stat;
	logic    pop;

	// front: accepts a transaction and sorts it into a lock kind
	wpl_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_stat        (q_stat),
		.push          (push),
		.push_req      (push_req)
	);

	// short queue so front and back stall on their own
	wpl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// back: walks the slots, applies the conflict rules, updates the table
	wpl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// the back end never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty request queue");

	// an accepted request is held in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !q_stat.empty)
		else $error("accepted request missing from queue");

	// a shown result is always one of the defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata <= OUT_DATA_W'(STAT_UNHELD)))
		else $error("undefined status code on output");

endmodule

`default_nettype wire
